// ===== hw/rtl/prv_pkg.sv =====
package prv_pkg;

  localparam int unsigned HEADER_LEN = 4;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES     = 32'hFFFF_FFFF;
  localparam logic [31:0] MAGIC_RESET  = 32'h4C41_434E;
  localparam logic [15:0] LAYOUT_RESET = 16'd4;

  // Raw op codes as they arrive on the input port
  localparam logic [2:0] OP_BEGIN     = 3'd0;
  localparam logic [2:0] OP_WORD      = 3'd1;
  localparam logic [2:0] OP_END       = 3'd2;
  localparam logic [2:0] OP_SAVE_RES  = 3'd3;
  localparam logic [2:0] OP_SAVE_WORD = 3'd4;

  typedef enum logic [2:0] {
    KIND_NONE      = 3'd0,
    KIND_BEGIN     = 3'd1,
    KIND_WORD      = 3'd2,
    KIND_END       = 3'd3,
    KIND_SAVE_RES  = 3'd4,
    KIND_SAVE_WORD = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    CLS_VALID   = 2'd0,
    CLS_BLANK   = 2'd1,
    CLS_STALE   = 2'd2,
    CLS_CORRUPT = 2'd3
  } class_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECORD_MAGIC   = 1'b0,
    REG_LAYOUT_VERSION = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] data_word;
    logic        sector_index;
    logic        last_word;
    logic        save_ok;
  } prv_in_t;

  typedef struct packed {
    class_e      record_class;
    logic        class_ready;
    logic        adopted;
    logic        have_active_out;
    logic        active_sector_out;
    logic [31:0] active_sequence_out;
    logic        save_target;
    logic [31:0] save_sequence;
    logic        fault;
    logic [31:0] payload_crc;
  } prv_out_t;

  // Classified word handed from the front to the back
  typedef struct packed {
    kind_e       kind;
    logic [31:0] data_word;
    logic        sector_index;
    logic        last_word;
    logic        save_ok;
  } prv_cmd_t;

  // Reflected CRC-32 update over one word, low byte first; flattens to an xor tree
  function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [31:0] w);
    logic [31:0] c;
    c = crc ^ w;
    for (int k = 0; k < 32; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/prv_front.sv =====
module prv_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  prv_pkg::prv_in_t in_word_i,
  output logic             cmd_valid_o,
  output prv_pkg::prv_cmd_t cmd_o,
  input  logic             cmd_pop_i
);
  import prv_pkg::*;

  prv_cmd_t   slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;
  prv_cmd_t   cmd_new;

  // Classify the raw op
  always_comb begin
    cmd_new.data_word    = in_word_i.data_word;
    cmd_new.sector_index = in_word_i.sector_index;
    cmd_new.last_word    = in_word_i.last_word;
    cmd_new.save_ok      = in_word_i.save_ok;
    unique case (in_word_i.op)
      OP_BEGIN:     cmd_new.kind = KIND_BEGIN;
      OP_WORD:      cmd_new.kind = KIND_WORD;
      OP_END:       cmd_new.kind = KIND_END;
      OP_SAVE_RES:  cmd_new.kind = KIND_SAVE_RES;
      OP_SAVE_WORD: cmd_new.kind = KIND_SAVE_WORD;
      default:      cmd_new.kind = KIND_NONE;
    endcase
  end

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ===== hw/rtl/prv_back.sv =====
module prv_back #(
  parameter int unsigned PAYLOAD_WORDS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cmd_valid_i,
  input  prv_pkg::prv_cmd_t                   cmd_i,
  output logic                                cmd_pop_o,
  input  logic                                valid,
  output logic                                ready,
  input  logic [prv_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [31:0]                         cfg_data_i,
  output logic                                empty,
  input  logic                                pop,
  output prv_pkg::prv_out_t                   out_word_o
);
  import prv_pkg::*;

  localparam int unsigned FULL_POS = HEADER_LEN + PAYLOAD_WORDS;
  localparam int unsigned POS_W    = $clog2(FULL_POS + 1);
  localparam logic [15:0] WANT_LEN = 16'((PAYLOAD_WORDS * 4) % 65536);
  localparam logic [POS_W-1:0] POS_FULL = POS_W'(FULL_POS);
  localparam logic [POS_W-1:0] POS_HDR  = POS_W'(HEADER_LEN);

  logic [31:0]      magic_q;
  logic [15:0]      layout_q;
  logic             have_q, have_d;
  logic             sec_q, sec_d;
  logic [31:0]      seq_q, seq_d;
  logic             corrupt_q, corrupt_d;
  logic             fault_q, fault_d;
  logic [31:0]      acc_q, acc_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [31:0]      hdr_q [4];
  logic [31:0]      hdr_d [4];
  logic [31:0]      hdr_eff [4];
  logic [31:0]      acc_base;
  logic [31:0]      crc_show;
  logic [31:0]      seq_diff;
  logic             take;
  logic             out_valid_q, out_valid_d;
  prv_out_t         out_q, out_d;
  class_e           cls;
  logic             cls_rdy;
  logic             adopt;

  assign ready     = 1'b1;
  assign take      = cmd_valid_i && (!out_valid_q || pop);
  assign cmd_pop_o = take;
  assign empty     = !out_valid_q;
  assign out_word_o = out_q;

  always_comb begin
    have_d    = have_q;
    sec_d     = sec_q;
    seq_d     = seq_q;
    corrupt_d = corrupt_q;
    fault_d   = fault_q;
    acc_d     = acc_q;
    pos_d     = pos_q;
    hdr_d     = hdr_q;
    hdr_eff   = hdr_q;
    cls       = CLS_VALID;
    cls_rdy   = 1'b0;
    adopt     = 1'b0;
    acc_base  = (pos_q == '0) ? CRC_ONES : acc_q;
    seq_diff  = hdr_q[2] - seq_q;
    crc_show  = acc_q ^ CRC_ONES;
    if (take) begin
      unique case (cmd_i.kind)
        KIND_BEGIN: begin
          have_d    = 1'b0;
          sec_d     = 1'b0;
          seq_d     = '0;
          corrupt_d = 1'b0;
          pos_d     = '0;
          acc_d     = CRC_ONES;
          for (int i = 0; i < 4; i++) hdr_d[i] = '0;
          crc_show  = '0;
        end
        KIND_WORD: begin
          acc_d = acc_base;
          if (pos_q < POS_HDR) begin
            hdr_eff[pos_q[1:0]] = cmd_i.data_word;
          end else if (pos_q < POS_FULL) begin
            acc_d = crc_fold(acc_base, cmd_i.data_word);
          end
          if (pos_q < POS_FULL) begin
            pos_d = pos_q + POS_W'(1);
          end
          hdr_d    = hdr_eff;
          crc_show = acc_d ^ CRC_ONES;
          seq_diff = hdr_eff[2] - seq_q;
          if (cmd_i.last_word) begin
            cls_rdy = 1'b1;
            if (hdr_eff[0] != magic_q) begin
              cls = CLS_BLANK;
            end else if (hdr_eff[1][15:0] != layout_q) begin
              cls = CLS_STALE;
            end else if (pos_d == POS_FULL && hdr_eff[1][31:16] == WANT_LEN &&
                         hdr_eff[3] == crc_show) begin
              cls = CLS_VALID;
              // Adopt when nothing is active or the sequence is serially not older
              if (!have_q || !seq_diff[31]) begin
                have_d = 1'b1;
                sec_d  = cmd_i.sector_index;
                seq_d  = hdr_eff[2];
                adopt  = 1'b1;
              end
            end else begin
              cls       = CLS_CORRUPT;
              corrupt_d = 1'b1;
            end
            pos_d = '0;
            for (int i = 0; i < 4; i++) hdr_d[i] = '0;
          end
        end
        KIND_END: begin
          fault_d = !have_q && corrupt_q;
          pos_d   = '0;
        end
        KIND_SAVE_RES: begin
          if (cmd_i.save_ok) begin
            sec_d   = have_q ? ~sec_q : 1'b0;
            have_d  = 1'b1;
            seq_d   = seq_q + 32'd1;
            fault_d = 1'b0;
          end else begin
            fault_d = 1'b1;
          end
          acc_d    = CRC_ONES;
          crc_show = '0;
        end
        KIND_SAVE_WORD: begin
          crc_show = crc_fold(acc_q, cmd_i.data_word) ^ CRC_ONES;
          acc_d    = cmd_i.last_word ? CRC_ONES : (crc_show ^ CRC_ONES);
        end
        KIND_NONE: begin
        end
        default: begin
        end
      endcase
    end

    out_d.record_class        = cls;
    out_d.class_ready         = cls_rdy;
    out_d.adopted             = adopt;
    out_d.have_active_out     = have_d;
    out_d.active_sector_out   = sec_d;
    out_d.active_sequence_out = seq_d;
    out_d.save_target         = have_d ? ~sec_d : 1'b0;
    out_d.save_sequence       = seq_d + 32'd1;
    out_d.fault               = fault_d;
    out_d.payload_crc         = crc_show;

    out_valid_d = take ? 1'b1 : (pop ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q     <= MAGIC_RESET;
      layout_q    <= LAYOUT_RESET;
      have_q      <= 1'b0;
      sec_q       <= 1'b0;
      seq_q       <= '0;
      corrupt_q   <= 1'b0;
      fault_q     <= 1'b0;
      acc_q       <= CRC_ONES;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (valid && ready) begin
        unique case (cfg_idx_e'(cfg_index_i))
          REG_RECORD_MAGIC:   magic_q  <= cfg_data_i;
          REG_LAYOUT_VERSION: layout_q <= cfg_data_i[15:0];
          default: begin
          end
        endcase
      end
      have_q      <= have_d;
      sec_q       <= sec_d;
      seq_q       <= seq_d;
      corrupt_q   <= corrupt_d;
      fault_q     <= fault_d;
      acc_q       <= acc_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
    if (take) begin
      out_q <= out_d;
    end
  end

endmodule

// ===== hw/rtl/pingpong_record_validator.sv =====
// Channel   Direction  Handshake            Payload
// input     in         push / full          in_word_i   (op, data_word, sector_index, ...)
// result    out        empty / pop          out_word_o  (record_class ... payload_crc)
// config    in         valid / ready        cfg_index_i, cfg_data_i
//
// One word is accepted per cycle while full is low, and one result word comes back per
// accepted word. A result is on out_word_o once the queue has presented its word and the
// execute stage (CRC-32 xor tree, header checks) has registered it. Reset clears tracking
// state; header words stay unknown until a begin-scan word or a record end clears them.
// Config is always ready. A stalled result (pop low) holds the back end; the front keeps
// taking words until its two-entry queue fills and full rises.
module pingpong_record_validator #(
  parameter int unsigned PAYLOAD_WORDS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  prv_pkg::prv_in_t              in_word_i,
  output logic                          empty,
  input  logic                          pop,
  output prv_pkg::prv_out_t             out_word_o,
  input  logic                          valid,
  output logic                          ready,
  input  logic [prv_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);
  import prv_pkg::*;

  logic     cmd_valid;
  logic     cmd_pop;
  prv_cmd_t cmd;

  // Front: decode the op and queue the word
  prv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_word_i   (in_word_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Back: execute the word against tracking state and register the result
  prv_back #(
    .PAYLOAD_WORDS (PAYLOAD_WORDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .valid       (valid),
    .ready       (ready),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .empty       (empty),
    .pop         (pop),
    .out_word_o  (out_word_o)
  );

`ifndef NO_ASSERTIONS
  // Adoption only happens on a valid, classified record and leaves it active
  a_adopt_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_word_o.adopted) |->
      (out_word_o.class_ready && out_word_o.record_class == CLS_VALID &&
       out_word_o.have_active_out))
    else $error("adopted without a valid classified record");

  // The save target never points at the active sector
  a_target_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_word_o.have_active_out) |->
      (out_word_o.save_target != out_word_o.active_sector_out))
    else $error("save target equals active sector");

  // Next save sequence follows the active one
  a_save_seq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_word_o.save_sequence == out_word_o.active_sequence_out + 32'd1))
    else $error("save sequence mismatch");
`endif

endmodule

// ===== dv/pingpong_record_validator_tb.sv =====
module pingpong_record_validator_tb;
  import prv_pkg::*;

  localparam int unsigned PAYLOAD_WORDS = 16;
  localparam int unsigned RECORD_WORDS  = HEADER_LEN + PAYLOAD_WORDS;
  localparam logic [15:0] LEN_BYTES     = 16'(PAYLOAD_WORDS * 4);
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned MAX_REPORTS   = 10;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 push      = 1'b0;
  logic                 full;
  prv_in_t              in_word   = '0;
  logic                 empty;
  logic                 pop       = 1'b0;
  prv_out_t             out_word;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data  = '0;

  // Tracker copy of the block: configuration and state as after reset
  logic [31:0] cfg_magic        = MAGIC_RESET;
  logic [15:0] cfg_layout       = LAYOUT_RESET;
  logic        trk_have         = 1'b0;
  logic        trk_sector       = 1'b0;
  logic [31:0] trk_seq          = '0;
  logic        trk_corrupt_seen = 1'b0;
  logic        trk_fault        = 1'b0;
  logic [31:0] crc_acc          = CRC_ONES;
  int unsigned word_pos         = 0;
  logic [31:0] hdr [4]          = '{default: '0};

  prv_out_t    status_q [$];
  int unsigned mismatches  = 0;
  int unsigned words_sent  = 0;
  int unsigned cycle_count = 0;
  int unsigned pop_hold    = 0;
  bit          no_gaps     = 1'b0;

  pingpong_record_validator #(
    .PAYLOAD_WORDS(PAYLOAD_WORDS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word),
    .valid      (cfg_valid),
    .ready      (cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Mostly no gap, some short ones, a few long ones
  function automatic int unsigned pick_idle();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Reflected CRC-32, low byte of the word first
  function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [31:0] data);
    logic [31:0] c;
    c = acc;
    for (int b = 0; b < 4; b++) begin
      c[7:0] = c[7:0] ^ data[8*b +: 8];
      repeat (8) c = {1'b0, c[31:1]} ^ (c[0] ? CRC_POLY : 32'h0);
    end
    return c;
  endfunction

  // Advance the tracker by one accepted word and return the status it shows
  function automatic prv_out_t advance_tracker(input prv_in_t w);
    prv_out_t r;
    bit       restart_crc;
    r = '0;
    restart_crc = 1'b0;
    case (w.op)
      OP_BEGIN: begin
        trk_have         = 1'b0;
        trk_sector       = 1'b0;
        trk_seq          = '0;
        trk_corrupt_seen = 1'b0;
        word_pos         = 0;
        hdr              = '{default: '0};
        crc_acc          = CRC_ONES;
      end
      OP_WORD: begin
        if (word_pos == 0) crc_acc = CRC_ONES;
        if (word_pos < HEADER_LEN) hdr[word_pos] = w.data_word;
        else if (word_pos < RECORD_WORDS) crc_acc = crc32_step(crc_acc, w.data_word);
        if (word_pos < RECORD_WORDS) word_pos++;
        if (w.last_word) begin
          r.class_ready = 1'b1;
          if (hdr[0] != cfg_magic) begin
            r.record_class = CLS_BLANK;
          end else if (hdr[1][15:0] != cfg_layout) begin
            r.record_class = CLS_STALE;
          end else if (word_pos >= RECORD_WORDS && hdr[1][31:16] == LEN_BYTES &&
                       hdr[3] == ~crc_acc) begin
            r.record_class = CLS_VALID;
            // Adopt on first valid record or a serially newer-or-equal sequence
            if (!trk_have || (hdr[2] - trk_seq) < 32'h8000_0000) begin
              trk_have   = 1'b1;
              trk_sector = w.sector_index;
              trk_seq    = hdr[2];
              r.adopted  = 1'b1;
            end
          end else begin
            r.record_class   = CLS_CORRUPT;
            trk_corrupt_seen = 1'b1;
          end
          word_pos = 0;
          hdr      = '{default: '0};
        end
      end
      OP_END: begin
        trk_fault = !trk_have && trk_corrupt_seen;
        word_pos  = 0;
      end
      OP_SAVE_RES: begin
        if (w.save_ok) begin
          trk_sector = trk_have ? ~trk_sector : 1'b0;
          trk_have   = 1'b1;
          trk_seq    = trk_seq + 32'd1;
          trk_fault  = 1'b0;
        end else begin
          trk_fault = 1'b1;
        end
        crc_acc = CRC_ONES;
      end
      OP_SAVE_WORD: begin
        crc_acc     = crc32_step(crc_acc, w.data_word);
        restart_crc = w.last_word;
      end
      default: ;
    endcase
    r.have_active_out     = trk_have;
    r.active_sector_out   = trk_sector;
    r.active_sequence_out = trk_seq;
    r.save_target         = trk_have ? ~trk_sector : 1'b0;
    r.save_sequence       = trk_seq + 32'd1;
    r.fault               = trk_fault;
    r.payload_crc         = ~crc_acc;
    if (restart_crc) crc_acc = CRC_ONES;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch in %s: expected %h, got %h", name, want, got);
    end
  endtask

  // Compare each popped status word with the oldest one awaited
  always @(posedge clk_i) begin
    prv_out_t want;
    if (rst_ni && pop && !empty) begin
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected status word %h", out_word);
      end else begin
        want = status_q.pop_front();
        check_field("record_class", 32'(out_word.record_class), 32'(want.record_class));
        check_field("class_ready", 32'(out_word.class_ready), 32'(want.class_ready));
        check_field("adopted", 32'(out_word.adopted), 32'(want.adopted));
        check_field("have_active_out", 32'(out_word.have_active_out),
                    32'(want.have_active_out));
        check_field("active_sector_out", 32'(out_word.active_sector_out),
                    32'(want.active_sector_out));
        check_field("active_sequence_out", out_word.active_sequence_out,
                    want.active_sequence_out);
        check_field("save_target", 32'(out_word.save_target), 32'(want.save_target));
        check_field("save_sequence", out_word.save_sequence, want.save_sequence);
        check_field("fault", 32'(out_word.fault), 32'(want.fault));
        check_field("payload_crc", out_word.payload_crc, want.payload_crc);
      end
    end
  end

  // Stall the result side at random
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (pop_hold != 0) begin
      pop      <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else begin
      pop      <= 1'b1;
      pop_hold <= pick_idle();
    end
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("pingpong_record_validator test failed");
    $finish;
  end

  // Push one word, hold it until accepted, then advance the tracker
  task automatic send_word(input logic [2:0] op, input logic [31:0] data,
                           input logic sector, input logic last, input logic ok);
    prv_in_t     w;
    int unsigned gap;
    w.op           = op;
    w.data_word    = data;
    w.sector_index = sector;
    w.last_word    = last;
    w.save_ok      = ok;
    gap = pick_idle();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_word <= w;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    status_q.push_back(advance_tracker(w));
    words_sent++;
  endtask

  // Drop push and wait until every status word has come back
  task automatic quiesce();
    push <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    if (idx == REG_RECORD_MAGIC) cfg_magic = data;
    else cfg_layout = data[15:0];
  endtask

  // Build a record image and scan its first n_words words
  task automatic send_record(input logic sector, input logic [31:0] magic,
                             input logic [15:0] layout, input logic [15:0] len_bytes,
                             input logic [31:0] seq, input bit good_crc,
                             input int unsigned n_words);
    logic [31:0] image [$];
    logic [31:0] acc;
    logic [31:0] word;
    acc   = CRC_ONES;
    image = {magic, {len_bytes, layout}, seq, 32'h0};
    for (int i = 0; i < PAYLOAD_WORDS; i++) begin
      word = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? CRC_ONES : 32'h0)
                                         : $urandom;
      image.push_back(word);
      acc = crc32_step(acc, word);
    end
    image[3] = good_crc ? ~acc : ~acc ^ (32'h1 << $urandom_range(0, 31));
    while (image.size() < n_words) image.push_back($urandom);
    for (int i = 0; i < n_words; i++)
      send_word(OP_WORD, image[i], sector, i == n_words - 1, 1'($urandom_range(0, 1)));
  endtask

  task automatic test_record_classes();
    send_word(OP_BEGIN, CRC_ONES, 1'b1, 1'b1, 1'b1);
    // First valid record of a scan is adopted
    send_record(1'b0, cfg_magic, cfg_layout, LEN_BYTES, 32'd5, 1'b1, RECORD_WORDS);
    // Older sequence stays out, equal sequence with padding is adopted
    send_record(1'b1, cfg_magic, cfg_layout, LEN_BYTES, 32'd4, 1'b1, RECORD_WORDS);
    send_record(1'b1, cfg_magic, cfg_layout, LEN_BYTES, 32'd5, 1'b1, RECORD_WORDS + 3);
    // Exactly half the sequence space ahead does not count as newer
    send_record(1'b0, cfg_magic, cfg_layout, LEN_BYTES, 32'h8000_0005, 1'b1, RECORD_WORDS);
    // Bad CRC, bad length, payload cut short: all corrupt
    send_record(1'b0, cfg_magic, cfg_layout, LEN_BYTES, 32'd6, 1'b0, RECORD_WORDS);
    send_record(1'b0, cfg_magic, cfg_layout, LEN_BYTES + 16'd1, 32'd6, 1'b1, RECORD_WORDS);
    send_record(1'b0, cfg_magic, cfg_layout, LEN_BYTES, 32'd6, 1'b1, RECORD_WORDS - 1);
    // Header cut short: missing header words read as zero
    send_record(1'b0, cfg_magic, cfg_layout, LEN_BYTES, 32'd6, 1'b1, 2);
    send_record(1'b1, cfg_magic, cfg_layout, LEN_BYTES, 32'd6, 1'b1, 1);
    // Foreign magic is blank, foreign layout is stale
    send_record(1'b1, ~cfg_magic, cfg_layout, LEN_BYTES, 32'd7, 1'b1, RECORD_WORDS);
    send_record(1'b1, cfg_magic, cfg_layout ^ 16'h8000, LEN_BYTES, 32'd7, 1'b1, RECORD_WORDS);
    send_word(OP_END, 32'h0, 1'b0, 1'b0, 1'b0);
    // A scan with only corrupt records raises the fault at its end
    send_word(OP_BEGIN, 32'h0, 1'b0, 1'b0, 1'b0);
    send_record(1'b1, cfg_magic, cfg_layout, LEN_BYTES, 32'd9, 1'b0, RECORD_WORDS);
    send_word(OP_END, CRC_ONES, 1'b1, 1'b1, 1'b1);
    // Sequence wrap: zero is newer than all ones
    send_word(OP_BEGIN, $urandom, 1'b0, 1'b1, 1'b0);
    send_record(1'b1, cfg_magic, cfg_layout, LEN_BYTES, CRC_ONES, 1'b1, RECORD_WORDS);
    send_record(1'b0, cfg_magic, cfg_layout, LEN_BYTES, 32'h0, 1'b1, RECORD_WORDS);
    send_word(OP_END, 32'h0, 1'b1, 1'b0, 1'b1);
  endtask

  task automatic test_save_path();
    send_word(OP_SAVE_WORD, 32'h0, 1'b0, 1'b0, 1'b0);
    send_word(OP_SAVE_WORD, CRC_ONES, 1'b1, 1'b0, 1'b1);
    send_word(OP_SAVE_WORD, $urandom, 1'b0, 1'b1, 1'b0);
    send_word(OP_SAVE_RES, $urandom, 1'b1, 1'b1, 1'b0);
    send_word(OP_SAVE_RES, $urandom, 1'b0, 1'b0, 1'b1);
    send_word(OP_SAVE_RES, $urandom, 1'b1, 1'b0, 1'b1);
    // Save with no active record targets sector zero
    send_word(OP_BEGIN, 32'h0, 1'b0, 1'b0, 1'b1);
    send_word(OP_SAVE_RES, 32'h0, 1'b1, 1'b1, 1'b1);
    // Interleave a scanned word into a save stream: the scanned word restarts the shared CRC
    send_word(OP_SAVE_WORD, $urandom, 1'b0, 1'b0, 1'b0);
    send_word(OP_WORD, cfg_magic, 1'b1, 1'b0, 1'b0);
    send_word(OP_SAVE_WORD, $urandom, 1'b1, 1'b1, 1'b1);
    // Unused op codes change nothing
    for (int op = 5; op < 8; op++)
      send_word(3'(op), $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    // Hold off until every status word has come back
    quiesce();
  endtask

  task automatic test_config_sweep();
    logic [31:0] magics [4];
    logic [15:0] layouts [4];
    magics  = '{CRC_ONES, 32'h0, $urandom, MAGIC_RESET};
    layouts = '{16'hFFFF, 16'h0, 16'($urandom), LAYOUT_RESET};
    for (int s = 0; s < 4; s++) begin
      write_reg(REG_RECORD_MAGIC, magics[s]);
      write_reg(REG_LAYOUT_VERSION, {16'($urandom), layouts[s]});
      no_gaps = (s == 2);
      send_word(OP_BEGIN, $urandom, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
      send_record(1'($urandom_range(0, 1)), cfg_magic, cfg_layout, LEN_BYTES, $urandom,
                  1'b1, RECORD_WORDS);
      send_record(1'($urandom_range(0, 1)), cfg_magic, cfg_layout + 16'd1, LEN_BYTES,
                  $urandom, 1'b1, RECORD_WORDS);
      send_record(1'b0, cfg_magic, cfg_layout, LEN_BYTES, 32'h0, 1'b1, 1);
      // Lone zero word: blank unless the magic is zero
      send_word(OP_WORD, 32'h0, 1'b1, 1'b1, 1'b0);
      send_word(OP_END, 32'h0, 1'b0, 1'b1, 1'b0);
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_random_traffic(input int unsigned n);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned n_words;
    logic [31:0] seq;
    bit          paused;
    stop_at = words_sent + n;
    paused  = 1'b0;
    send_word(OP_BEGIN, $urandom, 1'b0, 1'b0, 1'b0);
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
      if (!paused && words_sent + n / 2 >= stop_at) begin
        quiesce();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        case ($urandom_range(0, 3))
          0:       seq = $urandom;
          1:       seq = trk_seq - 32'($urandom_range(1, 4));
          default: seq = trk_seq + 32'($urandom_range(0, 2));
        endcase
        case ($urandom_range(0, 9))
          0:       n_words = $urandom_range(1, RECORD_WORDS - 1);
          1:       n_words = RECORD_WORDS + $urandom_range(1, 4);
          default: n_words = RECORD_WORDS;
        endcase
        send_record(1'($urandom_range(0, 1)),
                    ($urandom_range(0, 6) != 0) ? cfg_magic : $urandom,
                    ($urandom_range(0, 6) != 0) ? cfg_layout : 16'($urandom),
                    ($urandom_range(0, 9) != 0) ? LEN_BYTES : 16'($urandom),
                    seq, $urandom_range(0, 6) != 0, n_words);
      end else if (pick < 78) begin
        send_word(OP_BEGIN, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end else if (pick < 85) begin
        send_word(OP_END, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end else if (pick < 92) begin
        n_words = $urandom_range(1, 4);
        for (int i = 0; i < n_words; i++)
          send_word(OP_SAVE_WORD, $urandom, 1'($urandom_range(0, 1)), i == n_words - 1,
                    1'($urandom_range(0, 1)));
        send_word(OP_SAVE_RES, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 3) != 0);
      end else begin
        // Noise: any op, any field
        send_word(3'($urandom_range(0, 7)), $urandom, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_record_classes();
    test_save_path();
    test_config_sweep();
    test_random_traffic(40);
    quiesce();
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("pingpong_record_validator test passed");
    end else begin
      $display("pingpong_record_validator test failed");
    end
    $finish;
  end

endmodule
